[src/prle_pkg.sv]
// shared types and constants of the plane run-length decoder
package prle_pkg;

  localparam int LEN_W     = 24;
  localparam int LONG_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int CFG_IDX_W = CFG_AW - 2;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0]  TAIL_BYTES = LEN_W'(4);
  localparam logic [LEN_W-1:0]  LIT_LEFT   = LEN_W'(5);
  localparam logic [LEN_W-1:0]  HELD_LAST  = LEN_W'(6);
  localparam logic [LEN_W-1:0]  ONE_BYTE   = LEN_W'(1);
  localparam logic [LEN_W-1:0]  TWO_BYTES  = LEN_W'(2);
  localparam logic [LONG_W-1:0] RUN_BIAS   = LONG_W'(2);
  localparam logic [BYTE_W-1:0] LONG_MARK  = 8'hFF;
  localparam logic [1:0]        LONG_LAST  = 2'd3;

  typedef enum logic [2:0] {
    PH_VALUE,
    PH_HELD,
    PH_LEN,
    PH_LONG,
    PH_TAIL
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_SINGLE,
    ACT_HOLD,
    ACT_PAIR,
    ACT_HELD_SINGLE,
    ACT_HELD_DOUBLE,
    ACT_LONG_START,
    ACT_LONG_BYTE,
    ACT_RUN,
    ACT_RUN_ZERO
  } act_t;

  typedef struct packed {
    logic              two;
    logic [BYTE_W-1:0] v0;
    logic [LEN_W-1:0]  len0;
    logic              done0;
    logic              ovr0;
    logic [BYTE_W-1:0] v1;
  } prle_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/prle_front.sv]
// front end: config registers, byte classification and plane bookkeeping
module prle_front import prle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              cmd_push,
  output prle_cmd_t         cmd
);

  logic [LEN_W-1:0]  plane_bytes_r, plane_bytes_nxt;
  logic              passthrough_r, passthrough_nxt;
  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [LONG_W-1:0] long_r, long_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LONG_W-1:0]    long_new;
  logic [LONG_W-1:0]    run_raw;
  logic [LEN_W-1:0]     room;
  logic                 run_ovr;
  logic [LEN_W-1:0]     run_len;
  act_t                 act;
  logic [LEN_W-1:0]     dec;
  logic [LEN_W-1:0]     bl_after;
  logic [LEN_W-1:0]     start_bl;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_PASSTHROUGH) begin
      prdata[0] = passthrough_r;
    end else begin
      prdata[LEN_W-1:0] = plane_bytes_r;
    end
  end

  // run length datapath
  assign long_new = long_r | (LONG_W'(in_byte) << {cnt_r, 3'b000});
  assign run_raw  = (phase_r == PH_LONG) ? long_new : (LONG_W'(in_byte) + RUN_BIAS);
  assign room     = bytes_left_r - TAIL_BYTES;
  assign run_ovr  = run_raw > LONG_W'(room);
  assign run_len  = run_ovr ? room : run_raw[LEN_W-1:0];

  // classify the byte
  always_comb begin
    act = ACT_NONE;
    if (bytes_left_r == '0) begin
      act = ACT_NONE;
    end else if (passthrough_r) begin
      act = ACT_SINGLE;
    end else begin
      unique case (phase_r)
        PH_VALUE: act = (bytes_left_r == LIT_LEFT) ? ACT_SINGLE : ACT_HOLD;
        PH_HELD: begin
          if (in_byte == held_r) begin
            act = ACT_PAIR;
          end else if (bytes_left_r == HELD_LAST) begin
            act = ACT_HELD_DOUBLE;
          end else begin
            act = ACT_HELD_SINGLE;
          end
        end
        PH_LEN: act = (in_byte == LONG_MARK) ? ACT_LONG_START : ACT_RUN;
        PH_LONG: begin
          if (cnt_r != LONG_LAST) begin
            act = ACT_LONG_BYTE;
          end else if (run_len == '0) begin
            act = ACT_RUN_ZERO;
          end else begin
            act = ACT_RUN;
          end
        end
        default: act = ACT_SINGLE;
      endcase
    end
  end

  always_comb begin
    unique case (act)
      ACT_SINGLE, ACT_HELD_SINGLE: dec = ONE_BYTE;
      ACT_HELD_DOUBLE:             dec = TWO_BYTES;
      ACT_RUN:                     dec = run_len;
      default:                     dec = '0;
    endcase
  end

  assign bl_after = bytes_left_r - dec;
  assign start_bl = (cfg_wr && cfg_idx == REG_PLANE_BYTES) ? pwdata[LEN_W-1:0]
                                                          : plane_bytes_r;

  // next state
  always_comb begin
    plane_bytes_nxt = plane_bytes_r;
    passthrough_nxt = passthrough_r;
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    held_nxt        = held_r;
    long_nxt        = long_r;
    cnt_nxt         = cnt_r;
    if (cfg_wr) begin
      if (cfg_idx == REG_PLANE_BYTES) begin
        plane_bytes_nxt = pwdata[LEN_W-1:0];
      end else begin
        passthrough_nxt = pwdata[0];
      end
      bytes_left_nxt = start_bl;
      phase_nxt      = (start_bl > TAIL_BYTES) ? PH_VALUE : PH_TAIL;
      held_nxt       = '0;
      long_nxt       = '0;
      cnt_nxt        = '0;
    end else if (accept && act != ACT_NONE) begin
      if (dec != '0 && bl_after == '0) begin
        // plane finished, next plane starts at once
        bytes_left_nxt = start_bl;
        phase_nxt      = (start_bl > TAIL_BYTES) ? PH_VALUE : PH_TAIL;
        held_nxt       = '0;
        long_nxt       = '0;
        cnt_nxt        = '0;
      end else begin
        bytes_left_nxt = bl_after;
        unique case (act)
          ACT_SINGLE: begin
            if (bl_after <= TAIL_BYTES) begin
              phase_nxt = PH_TAIL;
            end
          end
          ACT_HOLD: begin
            held_nxt  = in_byte;
            phase_nxt = PH_HELD;
          end
          ACT_PAIR: phase_nxt = PH_LEN;
          ACT_HELD_SINGLE: begin
            held_nxt  = in_byte;
            phase_nxt = PH_HELD;
          end
          ACT_HELD_DOUBLE: phase_nxt = PH_TAIL;
          ACT_LONG_START: begin
            long_nxt  = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_LONG;
          end
          ACT_LONG_BYTE: begin
            long_nxt = long_new;
            cnt_nxt  = cnt_r + 2'd1;
          end
          ACT_RUN: begin
            if (phase_r == PH_LONG) begin
              long_nxt = long_new;
              cnt_nxt  = '0;
            end
            phase_nxt = (bl_after > TAIL_BYTES) ? PH_VALUE : PH_TAIL;
          end
          ACT_RUN_ZERO: begin
            long_nxt  = long_new;
            cnt_nxt   = '0;
            phase_nxt = PH_VALUE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // command to the back end
  always_comb begin
    cmd       = '0;
    cmd_push  = 1'b0;
    cmd.len0  = ONE_BYTE;
    cmd.v1    = in_byte;
    unique case (act)
      ACT_SINGLE: begin
        cmd_push  = accept & ~cfg_wr;
        cmd.v0    = in_byte;
        cmd.done0 = (bl_after == '0);
      end
      ACT_HELD_SINGLE: begin
        cmd_push = accept & ~cfg_wr;
        cmd.v0   = held_r;
      end
      ACT_HELD_DOUBLE: begin
        cmd_push = accept & ~cfg_wr;
        cmd.two  = 1'b1;
        cmd.v0   = held_r;
      end
      ACT_RUN: begin
        cmd_push = accept & ~cfg_wr;
        cmd.v0   = held_r;
        cmd.len0 = run_len;
        cmd.ovr0 = run_ovr;
      end
      default: cmd_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_bytes_r <= '0;
      passthrough_r <= 1'b0;
      phase_r       <= PH_TAIL;
      bytes_left_r  <= '0;
      held_r        <= '0;
      long_r        <= '0;
      cnt_r         <= '0;
    end else begin
      plane_bytes_r <= plane_bytes_nxt;
      passthrough_r <= passthrough_nxt;
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      held_r        <= held_nxt;
      long_r        <= long_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  a_tail_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != '0 && bytes_left_r <= TAIL_BYTES) |-> phase_r == PH_TAIL)
    else $error("tail bytes outside tail phase");

endmodule

[src/prle_cmd_q.sv]
// short command queue between front and back end
module prle_cmd_q import prle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  prle_cmd_t wdata,
  input  logic      pop,
  output prle_cmd_t rdata,
  output q_stat_t   stat
);

  prle_cmd_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_wr;
  logic               do_rd;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = push & ~stat.full;
  assign do_rd      = pop & ~stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(do_wr) - Q_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count past depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + Q_CNT_W'(1))
    else $error("queue count missed a write");

endmodule

[src/prle_back.sv]
// back end: expands commands into result beats behind an output register
module prle_back import prle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  prle_cmd_t         q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [BYTE_W-1:0] run_value,
  output logic [LEN_W-1:0]  run_length,
  output logic              plane_done,
  output logic              overrun
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              done_r, done_nxt;
  logic              ovr_r, ovr_nxt;
  logic              pend_r, pend_nxt;
  logic [BYTE_W-1:0] pend_val_r, pend_val_nxt;
  logic              load_ok;

  assign load_ok = ~out_valid_r | pop;
  assign q_pop   = load_ok & ~pend_r & ~q_stat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    val_nxt       = val_r;
    len_nxt       = len_r;
    done_nxt      = done_r;
    ovr_nxt       = ovr_r;
    pend_nxt      = pend_r;
    pend_val_nxt  = pend_val_r;
    if (load_ok) begin
      if (pend_r) begin
        // second literal of a two-beat command
        out_valid_nxt = 1'b1;
        val_nxt       = pend_val_r;
        len_nxt       = ONE_BYTE;
        done_nxt      = 1'b0;
        ovr_nxt       = 1'b0;
        pend_nxt      = 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_nxt = 1'b1;
        val_nxt       = q_data.v0;
        len_nxt       = q_data.len0;
        done_nxt      = q_data.done0;
        ovr_nxt       = q_data.ovr0;
        pend_nxt      = q_data.two;
        pend_val_nxt  = q_data.v1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    len_r      <= len_nxt;
    done_r     <= done_nxt;
    ovr_r      <= ovr_nxt;
    pend_val_r <= pend_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign empty      = ~out_valid_r;
  assign run_value  = val_r;
  assign run_length = len_r;
  assign plane_done = done_r;
  assign overrun    = ovr_r;

  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("pending literal without a shown beat");

endmodule

[src/plane_rle_run_decoder_top.sv]
// top level of the plane run-length decoder
//
// usage:
//   input channel: one compressed byte per beat on in_byte, taken when push is
//   high and full is low. bytes may arrive every cycle.
//   result channel: runs (value, length, plane_done, overrun) read like a queue;
//   the oldest run is on the out_ ports while empty is low and leaves on pop.
//   config: apb-style port, plane_bytes at address 0, passthrough at address 4;
//   writing either register restarts the plane. write only while idle.
//   path: a run's command passes the command queue, then the output register.
//   throughput: one byte per cycle in while full is low; one run per cycle out
//   with pop high; a byte's two literals leave the single output reg in turn.
//   a four-entry command queue sits between the byte classifier and the output
//   stage; when the receiver stalls the queue fills and full rises, so bytes
//   are held off without loss.
//   reset: plane_bytes and passthrough clear, queue and outputs empty; with a
//   zero plane size all bytes are dropped until plane_bytes is written.
module plane_rle_run_decoder_top import prle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              pop,
  output logic              empty,
  output logic [BYTE_W-1:0] out_run_value,
  output logic [LEN_W-1:0]  out_run_length,
  output logic              out_plane_done,
  output logic              out_overrun,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  q_stat_t   q_stat;
  prle_cmd_t cmd_in;
  prle_cmd_t cmd_out;
  logic      cmd_push;
  logic      cmd_pop;
  logic      accept;

  assign full   = q_stat.full;
  assign accept = push & ~q_stat.full;

  prle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .accept   (accept),
    .in_byte  (in_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  prle_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .stat  (q_stat)
  );

  prle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (cmd_out),
    .q_pop      (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .run_value  (out_run_value),
    .run_length (out_run_length),
    .plane_done (out_plane_done),
    .overrun    (out_overrun)
  );

endmodule
